FILE: design/tptach_pkg.sv
// Package for the tooth period tachometer: sizes, config indexes, queue item and
// back-end state types. No dependencies.
package tptach_pkg;

    localparam int WINDOW      = 16;
    localparam int LOG_WIN     = $clog2(WINDOW);
    localparam int SLOT_W      = (WINDOW > 1) ? LOG_WIN : 1;
    localparam int PERIOD_W    = 32;
    localparam int COUNT_W     = 32;
    localparam int RPM_W       = 32;
    localparam int TEETH_W     = 16;
    localparam int CLK_HZ_W    = 30;
    localparam int SUM_W       = PERIOD_W + LOG_WIN;
    localparam int NUM_W       = 36 + LOG_WIN;
    localparam int DEN_W       = SUM_W + TEETH_W;
    localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
    localparam int RPM_SCALE   = 60 * WINDOW;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CLK_HZ_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEETH_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = 2'd1;

    localparam logic [TEETH_W-1:0]  TEETH_RESET  = 16'd1;
    localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 30'd600000000;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  tooth;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic  empty;
        item_t item;
    } head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } back_state_t;

endpackage

FILE: design/tptach_front.sv
// Front end of the tachometer: input transfer and tooth numbering.
// Depends on tptach_pkg.
module tptach_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tptach_pkg::PERIOD_W-1:0] period_cycles,
    input  logic                           queue_full,
    output tptach_pkg::push_t              push
);
    import tptach_pkg::*;

    logic [COUNT_W-1:0] tooth_reg;
    logic [COUNT_W-1:0] tooth_next;
    logic               take;

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;

    always_comb
    begin
        tooth_next = tooth_reg;
        if (take)
        begin
            tooth_next = tooth_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tooth_reg <= '0;
        end
        else
        begin
            tooth_reg <= tooth_next;
        end
    end

    assign push.valid       = take;
    assign push.item.period = period_cycles;
    assign push.item.tooth  = tooth_reg + COUNT_W'(1);

endmodule

FILE: design/tptach_queue.sv
// Two-entry queue between the front and back ends.
// Depends on tptach_pkg.
module tptach_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tptach_pkg::push_t push,
    output logic              full,
    input  logic              pop,
    output tptach_pkg::head_t head
);
    import tptach_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.empty = (cnt_reg == '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && !head.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

FILE: design/tptach_back.sv
// Back end: period window memory, running sum, denominator multiply,
// bit-serial restoring divider and output register. Depends on tptach_pkg.
module tptach_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tptach_pkg::head_t               head,
    output logic                            pop,
    input  logic [tptach_pkg::TEETH_W-1:0]  teeth_per_rev,
    input  logic [tptach_pkg::CLK_HZ_W-1:0] clock_hz,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tptach_pkg::RPM_W-1:0]    rpm,
    output logic [tptach_pkg::COUNT_W-1:0]  tooth_count
);
    import tptach_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic [PERIOD_W-1:0]  win_mem [WINDOW];
    logic [PERIOD_W-1:0]  rd_reg;
    logic [WINDOW-1:0]    vld_reg;
    logic [WINDOW-1:0]    vld_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    item_t                cur_reg;
    item_t                cur_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     den_next;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     num_next;
    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     quo_next;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RPM_W-1:0]     rpm_reg;
    logic [RPM_W-1:0]     rpm_next;
    logic [COUNT_W-1:0]   tooth_reg;
    logic [COUNT_W-1:0]   tooth_next;

    logic                 mem_rd;
    logic                 win_upd;
    logic                 load_den;
    logic                 div_step;
    logic                 load_out;
    logic                 out_free;
    logic [PERIOD_W-1:0]  old_period;
    logic [DEN_W:0]       partial;
    logic [DEN_W:0]       trial;
    logic [RPM_W-1:0]     rpm_val;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!head.empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        mem_rd   = 1'b0;
        win_upd  = 1'b0;
        load_den = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: mem_rd   = !head.empty;
            ST_READ: win_upd  = 1'b1;
            ST_MUL:  load_den = 1'b1;
            ST_DIV:  div_step = 1'b1;
            ST_HOLD: load_out = out_free;
            default: ;
        endcase
    end

    assign pop = mem_rd;

    assign old_period = vld_reg[slot_reg] ? rd_reg : '0;
    assign partial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial      = partial - {1'b0, den_reg};

    always_comb
    begin
        if (den_reg == '0)
        begin
            rpm_val = '0;
        end
        else if (quo_reg[NUM_W-1:RPM_W] != '0)
        begin
            rpm_val = '1;
        end
        else
        begin
            rpm_val = quo_reg[RPM_W-1:0];
        end
    end

    // datapath
    always_comb
    begin
        vld_next       = vld_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        cur_next       = cur_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rpm_next       = rpm_reg;
        tooth_next     = tooth_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (mem_rd)
        begin
            cur_next = head.item;
        end
        if (win_upd)
        begin
            vld_next[slot_reg] = 1'b1;
            sum_next = sum_reg - SUM_W'(old_period) + SUM_W'(cur_reg.period);
            if (slot_reg == SLOT_W'(WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
        if (load_den)
        begin
            den_next = DEN_W'(sum_reg) * DEN_W'(teeth_per_rev);
            num_next = NUM_W'(clock_hz) * NUM_W'(RPM_SCALE);
            quo_next = '0;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(NUM_W);
        end
        if (div_step)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            rpm_next       = rpm_val;
            tooth_next     = cur_reg.tooth;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        rpm_reg   <= rpm_next;
        tooth_reg <= tooth_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_reg <= win_mem[slot_reg];
        end
        if (win_upd)
        begin
            win_mem[slot_reg] <= cur_reg.period;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rpm         = rpm_reg;
    assign tooth_count = tooth_reg;

endmodule

FILE: design/tooth_period_tachometer_unit.sv
// Top level of the tooth period tachometer: config registers, front end, queue, back end.
// Depends on tptach_pkg, tptach_front, tptach_queue, tptach_back.
//
// Each accepted period yields one result: rpm = floor(60 * clock_hz * WINDOW /
// (window_sum * teeth_per_rev)), 0 for a zero divisor, saturated at 32 bits, plus the
// wrapping tooth count. The back end handles one period at a time, paced by the
// bit-serial restoring divider that produces one quotient bit per cycle. A two-entry
// queue lets up to two further periods be taken while the divider runs, and the
// result register holds a finished result while the next item is already in work.
// Write config only while idle.
module tooth_period_tachometer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tptach_pkg::PERIOD_W-1:0]   period_cycles,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tptach_pkg::RPM_W-1:0]      rpm,
    output logic [tptach_pkg::COUNT_W-1:0]    tooth_count,
    input  logic                              cfg_we,
    input  logic [tptach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tptach_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tptach_pkg::*;

    logic [TEETH_W-1:0]  teeth_reg;
    logic [TEETH_W-1:0]  teeth_next;
    logic [CLK_HZ_W-1:0] clock_hz_reg;
    logic [CLK_HZ_W-1:0] clock_hz_next;

    push_t push;
    head_t head;
    logic  queue_full;
    logic  pop;

    always_comb
    begin
        teeth_next    = teeth_reg;
        clock_hz_next = clock_hz_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEETH_PER_REV: teeth_next    = cfg_data[TEETH_W-1:0];
                CFG_CLOCK_HZ:      clock_hz_next = cfg_data[CLK_HZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            teeth_reg    <= TEETH_RESET;
            clock_hz_reg <= CLK_HZ_RESET;
        end
        else
        begin
            teeth_reg    <= teeth_next;
            clock_hz_reg <= clock_hz_next;
        end
    end

    tptach_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .period_cycles (period_cycles),
        .queue_full    (queue_full),
        .push          (push)
    );

    tptach_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head)
    );

    tptach_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .teeth_per_rev (teeth_reg),
        .clock_hz      (clock_hz_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rpm           (rpm),
        .tooth_count   (tooth_count)
    );

endmodule

FILE: design/tptach_check.sv
// Port-level checks for tooth_period_tachometer_unit, bound to the top level.
// Depends on tptach_pkg.
module tptach_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [tptach_pkg::RPM_W-1:0]      rpm,
    input logic [tptach_pkg::COUNT_W-1:0]    tooth_count
);
    import tptach_pkg::*;

    logic [7:0]         pend_reg;
    logic [7:0]         pend_next;
    logic [COUNT_W-1:0] last_reg;
    logic [COUNT_W-1:0] last_next;
    logic               in_xfer;
    logic               out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + 8'(in_xfer) - 8'(out_xfer);
        last_next = out_xfer ? tooth_count : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            last_reg <= last_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(rpm) && $stable(tooth_count))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("result without a pending item");

    a_tooth_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> tooth_count == last_reg + COUNT_W'(1))
        else $error("tooth count out of sequence");

endmodule

bind tooth_period_tachometer_unit tptach_check u_tptach_check (.*);
